/* rtl/scancode_to_ascii_fifo_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the scancode to ASCII buffer
// Shared concurrent assertion forms, all disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef SCANCODE_TO_ASCII_FIFO_DEFINES_SVH
`define SCANCODE_TO_ASCII_FIFO_DEFINES_SVH

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define SCTA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Whenever the antecedent holds, the consequent holds in the next cycle.
`define SCTA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// The expression must never be true.
`define SCTA_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

/* rtl/scta_pkg.sv */
// ----------------------------------------------------------------------------
// Scancode to ASCII package
// Scancode constants, key translation tables and shared types.
// ----------------------------------------------------------------------------
package scta_pkg;

    // Ring buffer size; one slot stays free to tell full from empty.
    localparam int BUFFER_DEPTH = 256;
    localparam int PTR_W        = $clog2(BUFFER_DEPTH);

    typedef enum logic {
        REQ_SCAN = 1'b0,
        REQ_POP  = 1'b1
    } req_kind_t;

    localparam logic [7:0] SC_PREFIX    = 8'hE0;
    localparam int         SC_BREAK_BIT = 7;
    localparam logic [6:0] SC_LSHIFT    = 7'h2A;
    localparam logic [6:0] SC_RSHIFT    = 7'h36;
    localparam logic [6:0] SC_CTRL      = 7'h1D;
    localparam logic [6:0] SC_ALT       = 7'h38;
    localparam logic [6:0] SC_CAPS      = 7'h3A;
    localparam logic [6:0] SC_KEY_C     = 7'h2E;
    localparam logic [6:0] SC_KEY_L     = 7'h26;

    localparam logic [6:0] CH_NUL     = 7'h00;
    localparam logic [6:0] CH_ETX     = 7'h03;
    localparam logic [6:0] CH_FF      = 7'h0C;
    localparam logic [6:0] CH_LOWER_A = 7'h61;
    localparam logic [6:0] CH_LOWER_Z = 7'h7A;
    localparam logic [6:0] CH_CASE    = 7'h20;

    typedef struct packed {
        logic       valid;
        logic [6:0] ch;
    } push_t;

    typedef struct packed {
        push_t push;
        logic  pop;
    } ring_cmd_t;

    function automatic logic is_letter(input logic [6:0] ch);
        is_letter = (ch >= CH_LOWER_A) && (ch <= CH_LOWER_Z);
    endfunction

    // Unshifted translation of a make code.
    function automatic logic [6:0] key_plain(input logic [6:0] key);
        case (key)
            7'h01: key_plain = 7'h1B;
            7'h02: key_plain = 7'h31;
            7'h03: key_plain = 7'h32;
            7'h04: key_plain = 7'h33;
            7'h05: key_plain = 7'h34;
            7'h06: key_plain = 7'h35;
            7'h07: key_plain = 7'h36;
            7'h08: key_plain = 7'h37;
            7'h09: key_plain = 7'h38;
            7'h0A: key_plain = 7'h39;
            7'h0B: key_plain = 7'h30;
            7'h0C: key_plain = 7'h2D;
            7'h0D: key_plain = 7'h3D;
            7'h0E: key_plain = 7'h08;
            7'h0F: key_plain = 7'h09;
            7'h10: key_plain = 7'h71;
            7'h11: key_plain = 7'h77;
            7'h12: key_plain = 7'h65;
            7'h13: key_plain = 7'h72;
            7'h14: key_plain = 7'h74;
            7'h15: key_plain = 7'h79;
            7'h16: key_plain = 7'h75;
            7'h17: key_plain = 7'h69;
            7'h18: key_plain = 7'h6F;
            7'h19: key_plain = 7'h70;
            7'h1A: key_plain = 7'h5B;
            7'h1B: key_plain = 7'h5D;
            7'h1C: key_plain = 7'h0A;
            7'h1E: key_plain = 7'h61;
            7'h1F: key_plain = 7'h73;
            7'h20: key_plain = 7'h64;
            7'h21: key_plain = 7'h66;
            7'h22: key_plain = 7'h67;
            7'h23: key_plain = 7'h68;
            7'h24: key_plain = 7'h6A;
            7'h25: key_plain = 7'h6B;
            7'h26: key_plain = 7'h6C;
            7'h27: key_plain = 7'h3B;
            7'h28: key_plain = 7'h27;
            7'h29: key_plain = 7'h60;
            7'h2B: key_plain = 7'h5C;
            7'h2C: key_plain = 7'h7A;
            7'h2D: key_plain = 7'h78;
            7'h2E: key_plain = 7'h63;
            7'h2F: key_plain = 7'h76;
            7'h30: key_plain = 7'h62;
            7'h31: key_plain = 7'h6E;
            7'h32: key_plain = 7'h6D;
            7'h33: key_plain = 7'h2C;
            7'h34: key_plain = 7'h2E;
            7'h35: key_plain = 7'h2F;
            7'h37: key_plain = 7'h2A;
            7'h39: key_plain = 7'h20;
            7'h4A: key_plain = 7'h2D;
            7'h4E: key_plain = 7'h2B;
            default: key_plain = CH_NUL;
        endcase
    endfunction

    // Shifted translation: symbols differ, letters go to upper case.
    function automatic logic [6:0] key_shift(input logic [6:0] key);
        logic [6:0] base;
        base = key_plain(key);
        case (key)
            7'h02: key_shift = 7'h21;
            7'h03: key_shift = 7'h40;
            7'h04: key_shift = 7'h23;
            7'h05: key_shift = 7'h24;
            7'h06: key_shift = 7'h25;
            7'h07: key_shift = 7'h5E;
            7'h08: key_shift = 7'h26;
            7'h09: key_shift = 7'h2A;
            7'h0A: key_shift = 7'h28;
            7'h0B: key_shift = 7'h29;
            7'h0C: key_shift = 7'h5F;
            7'h0D: key_shift = 7'h2B;
            7'h1A: key_shift = 7'h7B;
            7'h1B: key_shift = 7'h7D;
            7'h27: key_shift = 7'h3A;
            7'h28: key_shift = 7'h22;
            7'h29: key_shift = 7'h7E;
            7'h2B: key_shift = 7'h7C;
            7'h33: key_shift = 7'h3C;
            7'h34: key_shift = 7'h3E;
            7'h35: key_shift = 7'h3F;
            default: key_shift = is_letter(base) ? (base ^ CH_CASE) : base;
        endcase
    endfunction

endpackage

/* rtl/scta_if.sv */
// ----------------------------------------------------------------------------
// Scancode to ASCII channel interfaces
// Request channel (scancode or pop) and character result channel.
// ----------------------------------------------------------------------------
interface scta_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] scan_byte;

    modport source (output valid, output req_type, output scan_byte, input ready);
    modport sink   (input valid, input req_type, input scan_byte, output ready);
endinterface

interface scta_char_if;
    logic       valid;
    logic       ready;
    logic [6:0] char_out;
    logic       got_char;

    modport source (output valid, output char_out, output got_char, input ready);
    modport sink   (input valid, input char_out, input got_char, output ready);
endinterface

/* rtl/scta_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module scta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/scta_decode.sv */
// ----------------------------------------------------------------------------
// Scancode decoder
// Tracks prefix and modifier state and translates make codes to characters.
// ----------------------------------------------------------------------------
module scta_decode (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          scan_valid,
    input  logic [7:0]    scan_byte,
    output scta_pkg::push_t push
);
    import scta_pkg::*;

    logic       prefix_reg, prefix_next;
    logic       shift_reg, shift_next;
    logic       ctrl_reg, ctrl_next;
    logic       caps_reg, caps_next;
    logic [6:0] key;
    logic [6:0] base;
    logic [6:0] shifted;
    logic [6:0] ch;

    always_comb
    begin
        prefix_next = prefix_reg;
        shift_next  = shift_reg;
        ctrl_next   = ctrl_reg;
        caps_next   = caps_reg;
        key         = scan_byte[6:0];
        base        = key_plain(key);
        shifted     = key_shift(key);
        ch          = CH_NUL;
        if (scan_valid)
        begin
            if (scan_byte == SC_PREFIX)
            begin
                prefix_next = 1'b1;
            end
            else if (prefix_reg)
            begin
                // The byte after a prefix is dropped without side effects.
                prefix_next = 1'b0;
            end
            else if (scan_byte[SC_BREAK_BIT])
            begin
                if (key == SC_LSHIFT || key == SC_RSHIFT)
                begin
                    shift_next = 1'b0;
                end
                else if (key == SC_CTRL)
                begin
                    ctrl_next = 1'b0;
                end
            end
            else if (key == SC_LSHIFT || key == SC_RSHIFT)
            begin
                shift_next = 1'b1;
            end
            else if (key == SC_CTRL)
            begin
                ctrl_next = 1'b1;
            end
            else if (key == SC_ALT)
            begin
                // Alt is consumed and has no effect.
            end
            else if (key == SC_CAPS)
            begin
                caps_next = !caps_reg;
            end
            else if (ctrl_reg)
            begin
                if (key == SC_KEY_C)
                begin
                    ch = CH_ETX;
                end
                else if (key == SC_KEY_L)
                begin
                    ch = CH_FF;
                end
            end
            else if (is_letter(base))
            begin
                ch = (shift_reg ^ caps_reg) ? shifted : base;
            end
            else
            begin
                ch = shift_reg ? shifted : base;
            end
        end
        push.valid = (ch != CH_NUL);
        push.ch    = ch;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg <= 1'b0;
            shift_reg  <= 1'b0;
            ctrl_reg   <= 1'b0;
            caps_reg   <= 1'b0;
        end
        else
        begin
            prefix_reg <= prefix_next;
            shift_reg  <= shift_next;
            ctrl_reg   <= ctrl_next;
            caps_reg   <= caps_next;
        end
    end

endmodule

/* rtl/scta_ring.sv */
// ----------------------------------------------------------------------------
// Character ring buffer
// Read and write pointers over a RAM, with the registered pop result.
// ----------------------------------------------------------------------------
`include "scancode_to_ascii_fifo_defines.svh"

module scta_ring (
    input  logic                clk,
    input  logic                rst_n,
    input  scta_pkg::ring_cmd_t cmd,
    output logic                pop_ok,
    scta_char_if.source         rsp
);
    import scta_pkg::*;

    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(BUFFER_DEPTH - 1);

    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [PTR_W-1:0] wptr_inc;
    logic [PTR_W-1:0] rptr_inc;
    logic             out_valid_reg, out_valid_next;
    logic             got_reg, got_next;
    logic             empty;
    logic             full;
    logic             pop_fire;
    logic             ram_we;
    logic             ram_re;
    logic [6:0]       ram_rdata;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
        ptr_inc = (ptr == LAST_IDX) ? '0 : ptr + 1'b1;
    endfunction

    always_comb
    begin
        wptr_inc = ptr_inc(wptr_reg);
        rptr_inc = ptr_inc(rptr_reg);
        empty    = (wptr_reg == rptr_reg);
        full     = (wptr_inc == rptr_reg);
        pop_ok   = !out_valid_reg || rsp.ready;
        pop_fire = cmd.pop && pop_ok;
        ram_we   = cmd.push.valid && !full;
        ram_re   = pop_fire && !empty;

        wptr_next = ram_we ? wptr_inc : wptr_reg;
        rptr_next = ram_re ? rptr_inc : rptr_reg;

        if (pop_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
        got_next = pop_fire ? !empty : got_reg;
    end

    scta_ram #(
        .WIDTH (7),
        .DEPTH (BUFFER_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wptr_reg),
        .wdata (cmd.push.ch),
        .re    (ram_re),
        .raddr (rptr_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg      <= '0;
            rptr_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wptr_reg      <= wptr_next;
            rptr_reg      <= rptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        got_reg <= got_next;
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.got_char = got_reg;
    assign rsp.char_out = got_reg ? ram_rdata : CH_NUL;

    `SCTA_ASSERT_NEVER(a_ptr_range, clk, rst_n,
        (wptr_reg > LAST_IDX) || (rptr_reg > LAST_IDX),
        "ring pointer beyond buffer depth")
    `SCTA_ASSERT_NEVER(a_no_rw_clash, clk, rst_n, ram_we && ram_re,
        "push and pop in the same cycle")
    `SCTA_ASSERT_NEXT(a_pop_hit, clk, rst_n, pop_fire && !empty,
        out_valid_reg && got_reg, "pop of a filled ring gave no character")
    `SCTA_ASSERT_NEXT(a_pop_miss, clk, rst_n, pop_fire && empty,
        out_valid_reg && !got_reg && $stable(rptr_reg),
        "pop of an empty ring moved the read pointer")

endmodule

/* rtl/scancode_to_ascii_fifo.sv */
// ----------------------------------------------------------------------------
// Scancode set 1 to ASCII converter with character buffer
// Decodes keyboard bytes into characters, buffers them and serves pops.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock cycle on the request channel
// unless a pop waits in the input register: either a raw set 1 scancode
// byte or a request to pop one character. A transaction is first captured
// in an input register; in the next cycle the decoder updates the prefix,
// shift, ctrl and caps lock flags and, for a key that yields a character,
// writes it into the ring buffer RAM. A pop reads the RAM at the read pointer
// when it leaves the input register, and its result appears on the response
// channel from the RAM read register and a valid flag, where it is held until
// taken. Scancode transactions produce no response and never stall. A
// pop waits in the input register only while the previous pop result has not
// yet been taken, which is the one point where response backpressure reaches
// the request side. The buffer holds up to BUFFER_DEPTH-1 characters; further
// pushes are dropped. After reset the buffer is empty at once, with no
// clearing pass, since the pointers alone mark which entries hold data.
// ----------------------------------------------------------------------------
module scancode_to_ascii_fifo (
    input  logic      clk,
    input  logic      rst_n,
    scta_req_if.sink  req,
    scta_char_if.source rsp
);
    import scta_pkg::*;

    logic            in_valid_reg, in_valid_next;
    req_kind_t       in_type_reg;
    logic [7:0]      in_byte_reg;
    logic            in_fire;
    logic            stage_fire;
    logic            scan_valid;
    logic            pop_ok;
    push_t           push;
    ring_cmd_t       cmd;

    // A scancode always leaves the input register; a pop leaves it only when
    // the result register is free or being emptied in this cycle.
    always_comb
    begin
        stage_fire = in_valid_reg && ((in_type_reg != REQ_POP) || pop_ok);
        req.ready  = !in_valid_reg || stage_fire;
        in_fire    = req.valid && req.ready;
        if (in_fire)
        begin
            in_valid_next = 1'b1;
        end
        else if (stage_fire)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
        scan_valid = in_valid_reg && (in_type_reg == REQ_SCAN);
        cmd.push   = push;
        cmd.pop    = in_valid_reg && (in_type_reg == REQ_POP);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_type_reg <= req_kind_t'(req.req_type);
            in_byte_reg <= req.scan_byte;
        end
    end

    // Flag tracking and translation; at most one character per byte.
    scta_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .scan_valid (scan_valid),
        .scan_byte  (in_byte_reg),
        .push       (push)
    );

    // Ring buffer, RAM and the response register.
    scta_ring u_ring (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .pop_ok (pop_ok),
        .rsp    (rsp)
    );

endmodule

/* test/tb_scancode_to_ascii_fifo.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the scancode to ASCII converter with character buffer
// Drives scancode and pop transactions with random gaps and response stalls,
// predicts each pop answer from its own keyboard decoder and compares them.
// ----------------------------------------------------------------------------
module tb_scancode_to_ascii_fifo;
    import scta_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 3;
    // A full ring holds one character less than it has slots.
    localparam int RING_SLOTS   = BUFFER_DEPTH - 1;
    localparam int RANDOM_ITEMS = 650;
    // Pop answer stalls are bounded by sink_stall_max, so a short limit is enough.
    localparam int DRAIN_LIMIT  = 400;
    localparam int TAIL_CYCLES  = 8;

    // A few make codes that the directed tests use by name.
    localparam logic [7:0] KEY_A         = 8'h1E;
    localparam logic [7:0] KEY_Q         = 8'h10;
    localparam logic [7:0] KEY_1         = 8'h02;
    localparam logic [7:0] KEY_STAR      = 8'h37;
    localparam logic [7:0] KEY_PAD_MINUS = 8'h4A;
    localparam logic [7:0] KEY_PAD_PLUS  = 8'h4E;
    localparam logic [7:0] KEY_NONE_LOW  = 8'h00;
    localparam logic [7:0] KEY_NONE_HIGH = 8'h7F;

    // What one pop is expected to return.
    typedef struct packed {
        logic [6:0] ch;
        logic       got;
    } pop_answer_t;

    logic clk;
    logic rst_n;

    scta_req_if  req_ch ();
    scta_char_if rsp_ch ();

    scancode_to_ascii_fifo DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    // Keyboard decoder state kept by the testbench.
    logic [6:0]  plain_map [128];
    logic [6:0]  shift_map [128];
    logic        kb_shift  = 1'b0;
    logic        kb_ctrl   = 1'b0;
    logic        kb_caps   = 1'b0;
    logic        kb_prefix = 1'b0;
    logic [6:0]  char_fifo [$];
    pop_answer_t pop_answers [$];

    // Current idling profile of each side: upper bound of the per-transaction wait.
    int src_idle_max  = 0;
    int sink_stall_max = 0;

    int errors   = 0;
    int n_sent   = 0;
    int n_scans  = 0;
    int n_pops   = 0;
    int n_chars  = 0;
    int n_empty  = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------------
    // Scancode set 1 translation tables, plain and shifted.
    // ------------------------------------------------------------------------
    function automatic void map_keys(input int first, input string lo, input string hi);
        for (int i = 0; i < lo.len(); i++)
        begin
            plain_map[first + i] = 7'(lo[i]);
            shift_map[first + i] = 7'(hi[i]);
        end
    endfunction

    initial
    begin : key_tables
        for (int i = 0; i < 128; i++)
        begin
            plain_map[i] = CH_NUL;
            shift_map[i] = CH_NUL;
        end
        // Escape, backspace, tab and enter are the same in both tables.
        plain_map[8'h01] = 7'h1B;
        shift_map[8'h01] = 7'h1B;
        plain_map[8'h0E] = 7'h08;
        shift_map[8'h0E] = 7'h08;
        plain_map[8'h0F] = 7'h09;
        shift_map[8'h0F] = 7'h09;
        plain_map[8'h1C] = 7'h0A;
        shift_map[8'h1C] = 7'h0A;
        plain_map[8'h29] = 7'h60;
        shift_map[8'h29] = 7'h7E;
        map_keys(8'h02, "1234567890-=", "!@#$%^&*()_+");
        map_keys(8'h10, "qwertyuiop[]", "QWERTYUIOP{}");
        map_keys(8'h1E, "asdfghjkl;'", "ASDFGHJKL:\"");
        map_keys(8'h2B, "\\zxcvbnm,./", "|ZXCVBNM<>?");
        // The keypad keys and space ignore shift.
        map_keys(8'h37, "*", "*");
        map_keys(8'h39, " ", " ");
        map_keys(8'h4A, "-", "-");
        map_keys(8'h4E, "+", "+");
    end

    // ------------------------------------------------------------------------
    // Decoder prediction.
    // ------------------------------------------------------------------------

    // A push into a full ring is lost without any notice.
    function automatic void store_char(input logic [6:0] ch);
        if (char_fifo.size() < RING_SLOTS)
            char_fifo.push_back(ch);
    endfunction

    // Applies one accepted request to the predicted state. A pop leaves its
    // answer in pop_answers; a scancode only changes flags and the buffer.
    function automatic void decode_request(input req_kind_t kind, input logic [7:0] code);
        logic [6:0]  key;
        logic [6:0]  base;
        logic [6:0]  ch;
        pop_answer_t ans;
        key = code[6:0];
        if (kind == REQ_POP)
        begin
            n_pops++;
            if (char_fifo.size() == 0)
            begin
                ans.ch  = CH_NUL;
                ans.got = 1'b0;
                n_empty++;
            end
            else
            begin
                ans.ch  = char_fifo.pop_front();
                ans.got = 1'b1;
                n_chars++;
            end
            pop_answers.push_back(ans);
            return;
        end
        n_scans++;
        // A prefix stays pending through further prefixes, then eats one byte.
        if (code == SC_PREFIX)
        begin
            kb_prefix = 1'b1;
            return;
        end
        if (kb_prefix)
        begin
            kb_prefix = 1'b0;
            return;
        end
        // Only the shift and ctrl breaks matter; all other breaks are dropped.
        if (code[SC_BREAK_BIT])
        begin
            if (key == SC_LSHIFT || key == SC_RSHIFT)
                kb_shift = 1'b0;
            else if (key == SC_CTRL)
                kb_ctrl = 1'b0;
            return;
        end
        if (key == SC_LSHIFT || key == SC_RSHIFT)
        begin
            kb_shift = 1'b1;
            return;
        end
        if (key == SC_CTRL)
        begin
            kb_ctrl = 1'b1;
            return;
        end
        if (key == SC_ALT)
            return;
        if (key == SC_CAPS)
        begin
            kb_caps = !kb_caps;
            return;
        end
        // With ctrl held only C and L produce their control characters.
        if (kb_ctrl)
        begin
            if (key == SC_KEY_C)
                store_char(CH_ETX);
            else if (key == SC_KEY_L)
                store_char(CH_FF);
            return;
        end
        // Letters follow shift xor caps lock, everything else follows shift.
        base = plain_map[key];
        if (base >= CH_LOWER_A && base <= CH_LOWER_Z)
            ch = (kb_shift != kb_caps) ? shift_map[key] : base;
        else
            ch = kb_shift ? shift_map[key] : base;
        if (ch != CH_NUL)
            store_char(ch);
    endfunction

    // ------------------------------------------------------------------------
    // Request driver. It is entered and left just after a falling edge, and
    // keeps valid high between back-to-back transactions.
    // ------------------------------------------------------------------------
    task automatic send_request(input req_kind_t kind, input logic [7:0] code);
        int gap;
        gap = $urandom_range(0, src_idle_max);
        if (gap != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= kind;
        req_ch.scan_byte <= code;
        do
        begin
            @(posedge clk);
        end
        while (!req_ch.ready);
        decode_request(kind, code);
        n_sent++;
        @(negedge clk);
    endtask

    // Pops carry a random byte that the block has to ignore.
    task automatic send_pops(input int count);
        for (int i = 0; i < count; i++)
            send_request(REQ_POP, 8'($urandom));
    endtask

    // Holds the request side idle until every predicted answer has come back.
    task automatic wait_for_answers();
        int cycles;
        cycles = 0;
        req_ch.valid <= 1'b0;
        @(negedge clk);
        while (pop_answers.size() != 0 && cycles < DRAIN_LIMIT)
        begin
            @(negedge clk);
            cycles++;
        end
        if (pop_answers.size() != 0)
        begin
            $error("%0d character transactions never arrived", pop_answers.size());
            errors++;
            pop_answers.delete();
        end
    endtask

    // A make code from 0x01 to 0x39, modifiers included, with the keypad minus and plus keys now and then.
    function automatic logic [7:0] pick_key();
        if ($urandom_range(0, 9) == 0)
            return ($urandom_range(0, 1) != 0) ? KEY_PAD_MINUS : KEY_PAD_PLUS;
        return 8'($urandom_range(8'h01, 8'h39));
    endfunction

    // ------------------------------------------------------------------------
    // Response checker. Each character transaction is compared with the
    // oldest predicted answer; ready may then drop for a random stall up to sink_stall_max.
    // ------------------------------------------------------------------------
    initial
    begin : response_checker
        pop_answer_t want;
        int          stall;
        stall = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                if (pop_answers.size() == 0)
                begin
                    $error("character transaction with no pop outstanding: char_out %h got_char %b",
                           rsp_ch.char_out, rsp_ch.got_char);
                    errors++;
                end
                else
                begin
                    want = pop_answers.pop_front();
                    if (rsp_ch.char_out !== want.ch)
                    begin
                        $error("char_out mismatch: expected %h, actual %h",
                               want.ch, rsp_ch.char_out);
                        errors++;
                    end
                    if (rsp_ch.got_char !== want.got)
                    begin
                        $error("got_char mismatch: expected %b, actual %b",
                               want.got, rsp_ch.got_char);
                        errors++;
                    end
                end
                stall = $urandom_range(0, sink_stall_max);
            end
            @(negedge clk);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Empty pop, case handling through shift and caps lock, keypad keys and
    // unmapped codes at both ends of the make range.
    task automatic test_case_translation();
        src_idle_max   = 8;
        sink_stall_max = 8;
        send_pops(1);
        send_request(REQ_SCAN, KEY_A);
        send_request(REQ_SCAN, {1'b0, SC_LSHIFT});
        send_request(REQ_SCAN, KEY_A);
        send_request(REQ_SCAN, {1'b0, SC_CAPS});
        // Shift and caps lock together give lower case, symbols still shift.
        send_request(REQ_SCAN, KEY_A);
        send_request(REQ_SCAN, KEY_1);
        send_request(REQ_SCAN, {1'b1, SC_LSHIFT});
        send_request(REQ_SCAN, KEY_Q);
        send_request(REQ_SCAN, KEY_1);
        send_request(REQ_SCAN, {1'b0, SC_CAPS});
        send_request(REQ_SCAN, KEY_STAR);
        send_request(REQ_SCAN, KEY_PAD_MINUS);
        send_request(REQ_SCAN, KEY_PAD_PLUS);
        send_request(REQ_SCAN, KEY_NONE_LOW);
        send_request(REQ_SCAN, KEY_NONE_HIGH);
        send_pops(9);
        wait_for_answers();
    endtask

    // Ctrl chords, the 0xE0 prefix, alt, and breaks that change nothing.
    task automatic test_ctrl_and_prefix();
        src_idle_max   = 0;
        sink_stall_max = 0;
        send_request(REQ_SCAN, {1'b0, SC_CTRL});
        send_request(REQ_SCAN, {1'b0, SC_KEY_C});
        send_request(REQ_SCAN, {1'b0, SC_KEY_L});
        send_request(REQ_SCAN, KEY_A);
        send_request(REQ_SCAN, {1'b1, SC_CTRL});
        send_request(REQ_SCAN, SC_PREFIX);
        send_request(REQ_SCAN, SC_PREFIX);
        send_request(REQ_SCAN, KEY_A);
        send_request(REQ_SCAN, {1'b0, SC_ALT});
        send_request(REQ_SCAN, 8'hFF);
        send_request(REQ_SCAN, {1'b1, KEY_A[6:0]});
        send_request(REQ_SCAN, KEY_Q);
        send_pops(4);
        wait_for_answers();
    endtask

    // Overfills the ring with letters, then empties it and pops past the end.
    task automatic test_buffer_full();
        src_idle_max   = 1;
        sink_stall_max = 3;
        for (int i = 0; i < RING_SLOTS + 5; i++)
            send_request(REQ_SCAN, 8'($urandom_range(KEY_Q, 8'h19)));
        send_pops(RING_SLOTS + 3);
        wait_for_answers();
    endtask

    // Mostly well-formed typing with random keys, mixed with pops, stray
    // breaks, prefixed bytes and raw noise.
    task automatic test_random_typing();
        int start;
        int pick;
        int count;
        start = n_sent;
        while (n_sent - start < RANDOM_ITEMS)
        begin
            // Switch the idling profile now and then, including runs with none.
            if ($urandom_range(0, 39) == 0)
            begin
                pick = $urandom_range(0, 2);
                src_idle_max   = (pick == 0) ? 0 : ((pick == 1) ? 2 : 8);
                pick = $urandom_range(0, 2);
                sink_stall_max = (pick == 0) ? 0 : ((pick == 1) ? 2 : 8);
            end
            if ($urandom_range(0, 79) == 0)
                wait_for_answers();
            pick = $urandom_range(0, 99);
            if (pick < 30)
            begin
                send_pops($urandom_range(1, 3));
            end
            else if (pick < 45)
            begin
                // A single key press, half the time followed by a random break code.
                send_request(REQ_SCAN, pick_key());
                if ($urandom_range(0, 1) != 0)
                    send_request(REQ_SCAN, {1'b1, 7'($urandom_range(1, 8'h39))});
            end
            else if (pick < 55)
            begin
                send_request(REQ_SCAN, {1'b0, ($urandom_range(0, 1) != 0) ? SC_LSHIFT : SC_RSHIFT});
                count = $urandom_range(1, 4);
                for (int i = 0; i < count; i++)
                    send_request(REQ_SCAN, pick_key());
                send_request(REQ_SCAN, {1'b1, ($urandom_range(0, 1) != 0) ? SC_LSHIFT : SC_RSHIFT});
            end
            else if (pick < 62)
            begin
                send_request(REQ_SCAN, {1'b0, SC_CTRL});
                count = $urandom_range(1, 3);
                for (int i = 0; i < count; i++)
                begin
                    case ($urandom_range(0, 2))
                        0:       send_request(REQ_SCAN, {1'b0, SC_KEY_C});
                        1:       send_request(REQ_SCAN, {1'b0, SC_KEY_L});
                        default: send_request(REQ_SCAN, pick_key());
                    endcase
                end
                send_request(REQ_SCAN, {1'b1, SC_CTRL});
            end
            else if (pick < 67)
            begin
                send_request(REQ_SCAN, {1'b0, SC_CAPS});
            end
            else if (pick < 75)
            begin
                // Extended keys: one or two prefixes, then the swallowed byte.
                count = $urandom_range(1, 2);
                for (int i = 0; i < count; i++)
                    send_request(REQ_SCAN, SC_PREFIX);
                send_request(REQ_SCAN, 8'($urandom));
            end
            else if (pick < 88)
            begin
                send_request(REQ_SCAN, 8'($urandom));
            end
            else
            begin
                // Broken sequences: a modifier press or release out of place.
                case ($urandom_range(0, 3))
                    0:       send_request(REQ_SCAN, {1'b0, SC_CTRL});
                    1:       send_request(REQ_SCAN, {1'b1, SC_CTRL});
                    2:       send_request(REQ_SCAN, {1'b0, SC_LSHIFT});
                    default: send_request(REQ_SCAN, {1'b1, SC_RSHIFT});
                endcase
            end
        end
        wait_for_answers();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin : main_sequence
        clk              = 1'b0;
        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.req_type  = REQ_SCAN;
        req_ch.scan_byte = 8'h00;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_case_translation();
        test_ctrl_and_prefix();
        test_buffer_full();
        test_random_typing();

        wait_for_answers();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d scancode and %0d pop transactions.", n_scans, n_pops);
        $display("%0d characters came back, %0d pops found the buffer empty.",
                 n_chars, n_empty);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog: many times the length of the slowest correct run.
    initial
    begin : watchdog
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
